### src/i2a_pkg.sv
// Shared types, constants and microcode store for the integer to ASCII digit emitter.
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int CNT_W      = 6;

    localparam logic [7:0] ASCII_ZERO       = 8'd48;
    localparam logic [7:0] ASCII_HEX_OFFSET = 8'd55;
    localparam logic [7:0] ASCII_MINUS      = 8'd45;

    typedef enum logic [1:0] {
        FUNC_UDEC = 2'd0,
        FUNC_SDEC = 2'd1,
        FUNC_HEX  = 2'd2,
        FUNC_BIN  = 2'd3
    } func_t;

    typedef logic [2:0] upc_t;

    localparam upc_t PC_IDLE   = 3'd0;
    localparam upc_t PC_SIGN   = 3'd1;
    localparam upc_t PC_DABBLE = 3'd2;
    localparam upc_t PC_SETDEC = 3'd3;
    localparam upc_t PC_SKIP   = 3'd4;
    localparam upc_t PC_EMITN  = 3'd5;
    localparam upc_t PC_EMITB  = 3'd6;

    typedef enum logic [2:0] {
        UOP_WAIT,
        UOP_SIGN,
        UOP_DABBLE,
        UOP_SETDEC,
        UOP_SKIP,
        UOP_EMITN,
        UOP_EMITB
    } uop_t;

    typedef struct packed {
        uop_t op;
        upc_t next;
    } uword_t;

    typedef struct packed {
        logic step_done;
        logic finish;
    } useq_stat_t;

    function automatic uword_t ucode_rom(upc_t pc);
        uword_t w;
        case (pc)
            PC_IDLE:   w = '{op: UOP_WAIT,   next: PC_IDLE};
            PC_SIGN:   w = '{op: UOP_SIGN,   next: PC_DABBLE};
            PC_DABBLE: w = '{op: UOP_DABBLE, next: PC_SETDEC};
            PC_SETDEC: w = '{op: UOP_SETDEC, next: PC_SKIP};
            PC_SKIP:   w = '{op: UOP_SKIP,   next: PC_EMITN};
            PC_EMITN:  w = '{op: UOP_EMITN,  next: PC_IDLE};
            PC_EMITB:  w = '{op: UOP_EMITB,  next: PC_IDLE};
            default:   w = '{op: UOP_WAIT,   next: PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [7:0] digit_char(logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = ASCII_ZERO + {4'b0, d};
        end
        else
        begin
            c = ASCII_HEX_OFFSET + {4'b0, d};
        end
        return c;
    endfunction

endpackage

### src/i2a_in_if.sv
// Input channel: value, mode and bit count with valid/ready.
`timescale 1ns / 1ps

interface i2a_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] value;
    logic [5:0]  bit_count;

    modport source (output valid, output func, output value, output bit_count, input ready);
    modport sink (input valid, input func, input value, input bit_count, output ready);
endinterface

### src/i2a_out_if.sv
// Output channel: one ASCII character and last flag with valid/ready.
`timescale 1ns / 1ps

interface i2a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

### src/integer_to_ascii_digit_emitter_core.sv
// Top level: datapath of the integer to ASCII digit emitter under microcode control.
`timescale 1ns / 1ps

// Takes one item (mode, 32-bit value, bit count) and emits its ASCII characters
// most significant first, one beat each, last set on the final beat. One item is
// worked on at a time; the next is taken once the final character sits in the
// output register. An item passes through: for decimal, the accepting cycle, a sign
// step, a 32-step shift-add-3 loop at one value bit per cycle, a digit counter load,
// then ten digit slots with leading zeros dropped one per cycle; for signed decimal,
// the sign step also emits the minus beat; for hex, eight digit slots, leading zeros
// likewise dropped; for binary, bit_count beats, capped at 32 (a count of zero gives
// no beat). Stalls on the output hold the emitting steps.
module integer_to_ascii_digit_emitter_core
    import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2a_in_if.sink      din,
    i2a_out_if.source   dout
);

    uword_t     uword;
    useq_stat_t stat;

    i2a_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .func  (din.func),
        .stat  (stat),
        .uword (uword)
    );

    logic [VALUE_W-1:0] val_reg, val_next;
    logic [BCD_W-1:0]   sr_reg, sr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic               out_valid_reg;
    logic [7:0]         char_reg;
    logic               last_reg;

    logic               slot_free;
    logic               launch;
    logic [7:0]         launch_char;
    logic               launch_last;
    logic [BCD_W-1:0]   adj;
    logic [4:0]         bit_idx;
    logic               in_neg;

    assign slot_free = !out_valid_reg || dout.ready;
    assign bit_idx   = cnt_reg[4:0] - 5'd1;
    assign in_neg    = (func_t'(din.func) == FUNC_SDEC) && din.value[VALUE_W-1];

    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (sr_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = sr_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = sr_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        val_next       = val_reg;
        sr_next        = sr_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        din.ready      = 1'b0;
        launch         = 1'b0;
        launch_char    = ASCII_ZERO;
        launch_last    = 1'b0;
        stat.step_done = 1'b0;
        stat.finish    = 1'b0;
        case (uword.op)
            UOP_WAIT:
            begin
                din.ready = 1'b1;
                if (din.valid)
                begin
                    stat.step_done = 1'b1;
                    neg_next       = in_neg;
                    val_next       = in_neg ? (VALUE_W'(0) - din.value) : din.value;
                    case (func_t'(din.func))
                        FUNC_HEX:
                        begin
                            sr_next  = {din.value, {(BCD_W-VALUE_W){1'b0}}};
                            cnt_next = CNT_W'(HEX_DIGITS);
                        end
                        FUNC_BIN:
                        begin
                            sr_next  = '0;
                            cnt_next = (din.bit_count > CNT_W'(VALUE_W)) ?
                                       CNT_W'(VALUE_W) : din.bit_count;
                        end
                        default:
                        begin
                            sr_next  = '0;
                            cnt_next = CNT_W'(VALUE_W);
                        end
                    endcase
                end
            end
            UOP_SIGN:
            begin
                if (!neg_reg)
                begin
                    stat.step_done = 1'b1;
                end
                else if (slot_free)
                begin
                    launch         = 1'b1;
                    launch_char    = ASCII_MINUS;
                    stat.step_done = 1'b1;
                end
            end
            UOP_DABBLE:
            begin
                sr_next  = {adj[BCD_W-2:0], val_reg[VALUE_W-1]};
                val_next = {val_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    stat.step_done = 1'b1;
                end
            end
            UOP_SETDEC:
            begin
                cnt_next       = CNT_W'(DEC_DIGITS);
                stat.step_done = 1'b1;
            end
            UOP_SKIP:
            begin
                if ((cnt_reg > CNT_W'(1)) && (sr_reg[BCD_W-1 -: 4] == 4'd0))
                begin
                    sr_next  = {sr_reg[BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    stat.step_done = 1'b1;
                end
            end
            UOP_EMITN:
            begin
                if (slot_free)
                begin
                    launch      = 1'b1;
                    launch_char = digit_char(sr_reg[BCD_W-1 -: 4]);
                    launch_last = (cnt_reg == CNT_W'(1));
                    sr_next     = {sr_reg[BCD_W-5:0], 4'd0};
                    cnt_next    = cnt_reg - CNT_W'(1);
                    stat.finish = (cnt_reg == CNT_W'(1));
                end
            end
            UOP_EMITB:
            begin
                if (cnt_reg == '0)
                begin
                    stat.finish = 1'b1;
                end
                else if (slot_free)
                begin
                    launch      = 1'b1;
                    launch_char = ASCII_ZERO + {7'd0, val_reg[bit_idx]};
                    launch_last = (cnt_reg == CNT_W'(1));
                    cnt_next    = cnt_reg - CNT_W'(1);
                    stat.finish = (cnt_reg == CNT_W'(1));
                end
            end
            default:
            begin
                stat.finish = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (launch)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        sr_reg  <= sr_next;
        neg_reg <= neg_next;
        if (launch)
        begin
            char_reg <= launch_char;
            last_reg <= launch_last;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.character = char_reg;
    assign dout.last      = last_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (din.valid && din.ready) |=> !din.ready)
        else $error("input taken again right after an accepted beat");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (launch && launch_last) |=> (uword.op == UOP_WAIT))
        else $error("sequencer not idle after final character");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(VALUE_W))
        else $error("digit counter out of range");

    a_dec_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (uword.op == UOP_SKIP && neg_reg) |-> (sr_reg[BCD_W-1 -: 4] < 4'd10))
        else $error("non-decimal digit after conversion");

endmodule

### src/i2a_useq.sv
// Microcode sequencer: step counter, control store and mode dispatch.
`timescale 1ns / 1ps

module i2a_useq
    import i2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] func,
    input  useq_stat_t stat,
    output uword_t     uword
);

    upc_t pc_reg;
    upc_t pc_next;

    assign uword = ucode_rom(pc_reg);

    always_comb
    begin
        pc_next = pc_reg;
        if (stat.finish)
        begin
            pc_next = PC_IDLE;
        end
        else if (stat.step_done)
        begin
            if (uword.op == UOP_WAIT)
            begin
                case (func_t'(func))
                    FUNC_UDEC: pc_next = PC_SIGN;
                    FUNC_SDEC: pc_next = PC_SIGN;
                    FUNC_HEX:  pc_next = PC_SKIP;
                    default:   pc_next = PC_EMITB;
                endcase
            end
            else
            begin
                pc_next = uword.next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
